@@ hdl/cspk_pkg.sv @@
// Shared types, constants and helpers of the CAN signal packer with hex output.
package cspk_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BITS = 64;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned START_W    = 6;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned BYTES_W    = 4;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned NCHAR_W    = 5;
  localparam int unsigned NIB_IDX_W  = 4;

  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(64);
  localparam logic [BYTES_W-1:0] BYTES_MAX = BYTES_W'(8);

  // Frame positions at or beyond FRAME_BITS never carry a bit
  localparam logic [VAL_W-1:0] FRAME_MASK = {VAL_W{1'b1}} >> (VAL_W - FRAME_BITS);

  // Byte order codes
  localparam logic ORDER_MOTOROLA = 1'b0;
  localparam logic ORDER_INTEL    = 1'b1;

  // ASCII anchors
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] ASCII_A    = CHAR_W'(8'h41);
  localparam logic [3:0]        DEC_DIGITS = 4'd10;

  // Placed frame word handed from the placement pipe to the serializer
  typedef struct packed {
    logic [VAL_W-1:0]   word;   // Intel: frame; Motorola: byte-reversed frame
    logic               intel;
    logic               err;
    logic [NCHAR_W-1:0] nchar;
  } place_t;

  // Map one nibble to its upper-case ASCII hex digit
  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
    logic [CHAR_W-1:0] res;
    if (nib < DEC_DIGITS) begin
      res = ASCII_ZERO + CHAR_W'(nib);
    end else begin
      res = ASCII_A + CHAR_W'(nib - DEC_DIGITS);
    end
    return res;
  endfunction

endpackage

@@ hdl/cspk_place.sv @@
// Three-stage placement pipe: clamp inputs, width check and shift setup, barrel shift.
module cspk_place (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cspk_pkg::VAL_W-1:0]     raw_value_i,
  input  logic [cspk_pkg::START_W-1:0]   start_bit_i,
  input  logic [cspk_pkg::LEN_W-1:0]     bit_length_i,
  input  logic                           byte_order_i,
  input  logic [cspk_pkg::BYTES_W-1:0]   frame_bytes_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cspk_pkg::place_t               out_o
);
  import cspk_pkg::*;

  // Stage 1 registers
  logic                 s1_v_q;
  logic [VAL_W-1:0]     s1_val_q;
  logic [START_W-1:0]   s1_start_q;
  logic [LEN_W-1:0]     s1_len_q;
  logic                 s1_intel_q;
  logic [NCHAR_W-1:0]   s1_nchar_q;

  // Stage 2 registers
  logic                 s2_v_q;
  logic [VAL_W-1:0]     s2_val_q;
  logic                 s2_left_q;
  logic [START_W-1:0]   s2_amt_q;
  logic                 s2_err_q;
  logic                 s2_intel_q;
  logic [NCHAR_W-1:0]   s2_nchar_q;

  // Stage 3 registers
  logic                 s3_v_q;
  place_t               s3_q;

  logic s1_ready, s2_ready, s3_ready;

  // Backpressure chain: a stage moves when its successor is empty or moving
  assign s3_ready   = !s3_v_q || out_ready_i;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // Clamp length and byte count at the entry
  logic [LEN_W-1:0]   len_c;
  logic [BYTES_W-1:0] bytes_c;
  logic [NCHAR_W-1:0] nchar_c;

  always_comb begin
    len_c   = (bit_length_i > LEN_MAX) ? LEN_MAX : bit_length_i;
    bytes_c = (frame_bytes_i > BYTES_MAX) ? BYTES_MAX : frame_bytes_i;
    nchar_c = {bytes_c, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      // Drop items that emit no characters
      s1_v_q <= in_valid_i && (frame_bytes_i != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_val_q   <= raw_value_i;
      s1_start_q <= start_bit_i;
      s1_len_q   <= len_c;
      s1_intel_q <= (byte_order_i == ORDER_INTEL);
      s1_nchar_q <= nchar_c;
    end
  end

  // Width check and shift amount.
  // Motorola: map to linear index m = byte*8 + (7 - bit); the field then
  // occupies rising m, so the byte-reversed frame is the value shifted
  // left by 64 - m0 - len (right when negative).
  logic                 err_c;
  logic [START_W-1:0]   m0_c;
  logic [LEN_W:0]       msh_c;
  logic [LEN_W:0]       mneg_c;
  logic                 left_c;
  logic [START_W-1:0]   amt_c;

  always_comb begin
    err_c  = (s1_len_q == '0) || ((s1_val_q >> s1_len_q) != '0);
    m0_c   = {s1_start_q[START_W-1:3], ~s1_start_q[2:0]};
    msh_c  = (LEN_W+1)'(VAL_W) - (LEN_W+1)'(m0_c) - (LEN_W+1)'(s1_len_q);
    mneg_c = ~msh_c + (LEN_W+1)'(1);
    if (s1_intel_q) begin
      left_c = 1'b1;
      amt_c  = s1_start_q;
    end else if (msh_c[LEN_W]) begin
      left_c = 1'b0;
      amt_c  = mneg_c[START_W-1:0];
    end else begin
      left_c = 1'b1;
      amt_c  = msh_c[START_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      // A value too wide for its field places nothing
      s2_val_q   <= err_c ? '0 : s1_val_q;
      s2_left_q  <= left_c;
      s2_amt_q   <= amt_c;
      s2_err_q   <= err_c;
      s2_intel_q <= s1_intel_q;
      s2_nchar_q <= s1_nchar_q;
    end
  end

  // Barrel shift into frame alignment
  logic [VAL_W-1:0] word_c;

  always_comb begin
    word_c = s2_left_q ? (s2_val_q << s2_amt_q) : (s2_val_q >> s2_amt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_ready) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_v_q) begin
      s3_q.word  <= word_c;
      s3_q.intel <= s2_intel_q;
      s3_q.err   <= s2_err_q;
      s3_q.nchar <= s2_nchar_q;
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_o       = s3_q;

endmodule

@@ hdl/cspk_hex_ser.sv @@
// Frame holder that emits one ASCII hex character per beat, byte 0 first.
module cspk_hex_ser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cspk_pkg::place_t                  in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cspk_pkg::CHAR_W-1:0]       hex_char_o,
  output logic                              width_error_o,
  output logic                              last_o
);
  import cspk_pkg::*;

  logic                   v_q;
  logic [VAL_W-1:0]       frame_q;
  logic [NCHAR_W-1:0]     nchar_q;
  logic [NIB_IDX_W-1:0]   idx_q;
  logic                   err_q;

  logic                   fire;
  logic                   is_last;
  logic [VAL_W-1:0]       frame_c;
  logic [3:0]             nib;

  // Undo the Motorola byte reversal and drop bits past the frame
  always_comb begin
    for (int b = 0; b < VAL_W / 8; b++) begin
      frame_c[b*8 +: 8] = in_i.intel ? in_i.word[b*8 +: 8]
                                     : in_i.word[(VAL_W/8 - 1 - b)*8 +: 8];
    end
    frame_c = frame_c & FRAME_MASK;
  end

  // Pick the current nibble: high half of the byte first
  always_comb begin
    nib     = frame_q[{idx_q[NIB_IDX_W-1:1], ~idx_q[0], 2'b00} +: 4];
    is_last = (NCHAR_W'(idx_q) + NCHAR_W'(1)) == nchar_q;
  end

  assign fire       = v_q && !out_stall_i;
  assign in_ready_o = !v_q || (fire && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      idx_q <= '0;
    end else if (in_ready_o) begin
      // Load the next frame or go empty
      v_q   <= in_valid_i;
      idx_q <= '0;
    end else if (fire) begin
      // Advance to the next character
      idx_q <= idx_q + NIB_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      frame_q <= frame_c;
      nchar_q <= in_i.nchar;
      err_q   <= in_i.err;
    end
  end

  assign out_valid_o   = v_q;
  assign hex_char_o    = hex_digit(nib);
  assign width_error_o = err_q;
  assign last_o        = is_last;

endmodule

@@ hdl/can_signal_pack_hex_top.sv @@
// Top level of the CAN signal packer: placement pipe feeding the hex serializer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   input   | in        | in_valid_i / in_stall_o | raw_value, start_bit, bit_length,
//           |           |                         | byte_order, frame_bytes
//   output  | out       | out_valid_o/out_stall_i | hex_char, width_error, last
//
// An item passes the clamp, width-check and shift stages of the placement pipe, then gives
// 2*frame_bytes characters (frame_bytes clamped to 8), one per cycle while out_stall_i is low;
// the single character port of the serializer takes no new item until its last character leaves.
// The serializer loads the next frame in the cycle its last character leaves.
// Items with zero frame bytes give no character and are dropped at entry.
// Reset empties all stages; stalls hold every stage that cannot move.
module can_signal_pack_hex_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [cspk_pkg::VAL_W-1:0]       raw_value_i,
  input  logic [cspk_pkg::START_W-1:0]     start_bit_i,
  input  logic [cspk_pkg::LEN_W-1:0]       bit_length_i,
  input  logic                             byte_order_i,
  input  logic [cspk_pkg::BYTES_W-1:0]     frame_bytes_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [cspk_pkg::CHAR_W-1:0]      hex_char_o,
  output logic                             width_error_o,
  output logic                             last_o
);
  import cspk_pkg::*;

  logic   pl_valid;
  logic   pl_ready;
  place_t pl_data;

  cspk_place u_place (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_value_i   (raw_value_i),
    .start_bit_i   (start_bit_i),
    .bit_length_i  (bit_length_i),
    .byte_order_i  (byte_order_i),
    .frame_bytes_i (frame_bytes_i),
    .out_valid_o   (pl_valid),
    .out_ready_i   (pl_ready),
    .out_o         (pl_data)
  );

  cspk_hex_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (pl_valid),
    .in_ready_o    (pl_ready),
    .in_i          (pl_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hex_char_o    (hex_char_o),
    .width_error_o (width_error_o),
    .last_o        (last_o)
  );

  // A frame that has not shown its last character keeps going
  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("frame ended before its last character");

  // The width flag holds across the characters of one frame
  a_err_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> $stable(width_error_o))
    else $error("width flag changed inside a frame");

  // Every character is an upper-case hex digit
  a_hex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((hex_char_o >= 7'h30 && hex_char_o <= 7'h39) ||
                     (hex_char_o >= 7'h41 && hex_char_o <= 7'h46)))
    else $error("character outside the hex digit set");

  // A width error always comes with an all-zero frame
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && width_error_o) |-> (hex_char_o == 7'h30))
    else $error("field placed despite width error");

endmodule
